### rtl/core/rlfm_pkg.sv
// Package for the radial light falloff mask unit.
// Holds payload and sideband types, fixed-point widths and constants.
// No dependencies.
package rlfm_pkg;

  localparam int MaxDim   = 4096;
  localparam int CfgW     = 13;
  localparam int CoordW   = 12;
  localparam int ValW     = 8;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgW-1:0] WidthRst  = CfgW'(108);
  localparam logic [CfgW-1:0] HeightRst = CfgW'(26);

  // front end
  localparam int NumW  = 19;  // 100*coord + 50, 42*W, 106*H
  localparam int SNumW = 20;  // signed offset numerator
  localparam int MagW  = 19;  // |numerator| inside the frame, up to 106*H
  localparam int DenW  = 20;  // radius denominators
  localparam int DivW  = 35;  // mag*2^16 + den/2
  localparam int FracW = 16;

  // divider
  localparam int RemW  = 36;
  localparam int QuoW  = 17;

  // t and t^3
  localparam int SqW       = 34;
  localparam int SumW      = 35;
  localparam int AccW      = 40;
  localparam int NW        = 22;
  localparam int RecipProdW = 45;
  localparam int RecipSh   = 26;
  localparam logic [RecipProdW-1:0] Recip10 = RecipProdW'(6710887);
  localparam logic [AccW-1:0] RoundTerm = AccW'(327680);
  localparam int QW        = 19;
  localparam int TW        = 19;
  localparam logic [TW-1:0] OneQ16 = TW'(65536);
  localparam int TsqW      = 38;
  localparam int CubeFullW = 57;
  localparam int CubeSh    = 32;
  localparam int CubeW     = 24;

  // byte search
  localparam int KW    = 9;
  localparam int KsqW  = 18;
  localparam int ProdW = 42;
  localparam logic [ProdW-1:0] Lim = ProdW'(64'd17045913600);

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [ValW-1:0] mask_value;
    logic            outside_frame;
  } mask_out_t;

  typedef struct packed {
    logic valid;
    logic outside;
  } ctl_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [ValW-1:0]  m;
    logic [ValW-1:0]  cand;
    logic [KsqW-1:0]  ksq;
    logic [CubeW-1:0] c;
  } root_t;

endpackage

### rtl/core/rlfm_front.sv
// Front end: input register, frame check, offset numerators and radii, dividends.
// Three register stages. Depends on rlfm_pkg.
module rlfm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            in_valid_i,
  input  rlfm_pkg::pixel_in_t             in_data_i,
  input  logic [rlfm_pkg::CfgW-1:0]       width_i,
  input  logic [rlfm_pkg::CfgW-1:0]       height_i,
  output rlfm_pkg::ctl_t                  ctl_o,
  output logic [1:0][rlfm_pkg::DivW-1:0]  dividend_o,
  output logic [1:0][rlfm_pkg::DenW-1:0]  den_o
);
  import rlfm_pkg::*;

  // stage 1: input register
  logic              vld1_q;
  pixel_in_t         pix1_q;

  // stage 2
  ctl_t              ctl2_q;
  logic [NumW-1:0]   xn2_q, yn2_q, w42_2_q, h106_2_q;
  logic [DenW-1:0]   du2_q, dv2_q;
  logic [NumW-1:0]   xn_d, yn_d, w42_d, h106_d;
  logic [DenW-1:0]   w62, h155, du_d, dv_d;
  logic              outside_d;

  // stage 3
  ctl_t              ctl3_q;
  logic [1:0][DivW-1:0] div3_q;
  logic [1:0][DenW-1:0] den3_q;
  logic signed [SNumW-1:0] nu, nv;
  logic [SNumW-1:0]  au, av;
  logic [DivW-1:0]   divu_d, divv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (en_i) begin
      vld1_q <= in_valid_i;
      ctl2_q <= '{valid: vld1_q, outside: outside_d};
      ctl3_q <= ctl2_q;
    end
  end

  always_comb begin
    xn_d      = NumW'(pix1_q.pixel_x) * NumW'(100) + NumW'(50);
    yn_d      = NumW'(pix1_q.pixel_y) * NumW'(100) + NumW'(50);
    w42_d     = NumW'(width_i) * NumW'(42);
    h106_d    = NumW'(height_i) * NumW'(106);
    w62       = DenW'(width_i) * DenW'(62);
    h155      = DenW'(height_i) * DenW'(155);
    du_d      = (w62 > h155) ? w62 : h155;
    dv_d      = DenW'(height_i) * DenW'(135);
    outside_d = (CfgW'(pix1_q.pixel_x) >= width_i) || (CfgW'(pix1_q.pixel_y) >= height_i);
  end

  always_comb begin
    nu     = signed'({1'b0, xn2_q}) - signed'({1'b0, w42_2_q});
    nv     = signed'({1'b0, yn2_q}) - signed'({1'b0, h106_2_q});
    au     = nu[SNumW-1] ? SNumW'(-nu) : SNumW'(nu);
    av     = nv[SNumW-1] ? SNumW'(-nv) : SNumW'(nv);
    divu_d = DivW'({au[MagW-1:0], {FracW{1'b0}}}) + DivW'(du2_q[DenW-1:1]);
    divv_d = DivW'({av[MagW-1:0], {FracW{1'b0}}}) + DivW'(dv2_q[DenW-1:1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix1_q   <= in_data_i;
      xn2_q    <= xn_d;
      yn2_q    <= yn_d;
      w42_2_q  <= w42_d;
      h106_2_q <= h106_d;
      du2_q    <= du_d;
      dv2_q    <= dv_d;
      div3_q   <= {divv_d, divu_d};
      den3_q   <= {dv2_q, du2_q};
    end
  end

  assign ctl_o      = ctl3_q;
  assign dividend_o = div3_q;
  assign den_o      = den3_q;

endmodule

### rtl/core/rlfm_div.sv
// Two-lane restoring divider, one quotient bit per register stage.
// Gives round(|num| / den) in Q.16 for u and v. Depends on rlfm_pkg.
module rlfm_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  rlfm_pkg::ctl_t                  ctl_i,
  input  logic [1:0][rlfm_pkg::DivW-1:0]  dividend_i,
  input  logic [1:0][rlfm_pkg::DenW-1:0]  den_i,
  output rlfm_pkg::ctl_t                  ctl_o,
  output logic [1:0][rlfm_pkg::QuoW-1:0]  quo_o
);
  import rlfm_pkg::*;

  ctl_t                 ctl_q  [QuoW];
  div_lane_t [1:0]      lane_q [QuoW];

  for (genvar j = 0; j < QuoW; j++) begin : g_stage
    localparam int Bit = QuoW - 1 - j;
    ctl_t            ctl_in;
    div_lane_t [1:0] cur, nxt;

    if (j == 0) begin : g_first
      always_comb begin
        ctl_in = ctl_i;
        for (int l = 0; l < 2; l++) begin
          cur[l].rem = RemW'(dividend_i[l]);
          cur[l].den = den_i[l];
          cur[l].quo = '0;
        end
      end
    end else begin : g_next
      assign ctl_in = ctl_q[j-1];
      assign cur    = lane_q[j-1];
    end

    always_comb begin
      nxt = cur;
      for (int l = 0; l < 2; l++) begin
        if (cur[l].rem >= (RemW'(cur[l].den) << Bit)) begin
          nxt[l].rem      = cur[l].rem - (RemW'(cur[l].den) << Bit);
          nxt[l].quo[Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j] <= '0;
      end else if (en_i) begin
        ctl_q[j] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_q[j] <= nxt;
      end
    end
  end

  assign ctl_o    = ctl_q[QuoW-1];
  assign quo_o[0] = lane_q[QuoW-1][0].quo;
  assign quo_o[1] = lane_q[QuoW-1][1].quo;

endmodule

### rtl/core/rlfm_cube.sv
// Forms t = 1 + 2.6*(u^2+v^2) in Q3.16 and floor(t^3) in Q.16.
// Five register stages. Depends on rlfm_pkg.
module rlfm_cube (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  rlfm_pkg::ctl_t                  ctl_i,
  input  logic [1:0][rlfm_pkg::QuoW-1:0]  quo_i,
  output rlfm_pkg::ctl_t                  ctl_o,
  output logic [rlfm_pkg::CubeW-1:0]      cube_o
);
  import rlfm_pkg::*;

  ctl_t                   ctl_q [5];
  logic [SqW-1:0]         squ_q, sqv_q;
  logic [NW-1:0]          n_q;
  logic [QW-1:0]          q10_q;
  logic [TW-1:0]          t_q;
  logic [TsqW-1:0]        tsq_q;
  logic [CubeW-1:0]       c_q;

  logic [SumW-1:0]        s;
  logic [AccW-1:0]        acc;
  logic [RecipProdW-1:0]  rp;
  logic [TW-1:0]          t_d;
  logic [CubeFullW-1:0]   cube_full;

  always_comb begin
    s         = SumW'(squ_q) + SumW'(sqv_q);
    acc       = AccW'(s) * AccW'(26) + RoundTerm;
    rp        = RecipProdW'(n_q) * Recip10;
    t_d       = OneQ16 + TW'(q10_q);
    cube_full = CubeFullW'(tsq_q) * CubeFullW'(t_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) ctl_q[i] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < 5; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      squ_q <= SqW'(quo_i[0]) * SqW'(quo_i[0]);
      sqv_q <= SqW'(quo_i[1]) * SqW'(quo_i[1]);
      n_q   <= acc[FracW +: NW];
      q10_q <= rp[RecipSh +: QW];
      t_q   <= t_d;
      tsq_q <= TsqW'(t_d) * TsqW'(t_d);
      c_q   <= cube_full[CubeSh +: CubeW];
    end
  end

  assign ctl_o  = ctl_q[4];
  assign cube_o = c_q;

endmodule

### rtl/core/rlfm_root.sv
// Bitwise search for the largest m with (2m-1)^2 * C <= 260100 * 2^16.
// Two register stages per result bit. Depends on rlfm_pkg.
module rlfm_root (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  rlfm_pkg::ctl_t              ctl_i,
  input  logic [rlfm_pkg::CubeW-1:0]  cube_i,
  output rlfm_pkg::ctl_t              ctl_o,
  output logic [rlfm_pkg::ValW-1:0]   m_o
);
  import rlfm_pkg::*;

  ctl_t  ctl_a_q [ValW];
  ctl_t  ctl_b_q [ValW];
  root_t a_q     [ValW];
  root_t b_q     [ValW];

  for (genvar j = 0; j < ValW; j++) begin : g_bit
    localparam int Bit = ValW - 1 - j;
    ctl_t             ctl_in;
    root_t            cur, a_d, b_d;
    logic [KW-1:0]    k;
    logic [ProdW-1:0] prod;

    if (j == 0) begin : g_first
      always_comb begin
        ctl_in = ctl_i;
        cur    = '{m: '0, cand: '0, ksq: '0, c: cube_i};
      end
    end else begin : g_next
      assign ctl_in = ctl_b_q[j-1];
      assign cur    = b_q[j-1];
    end

    always_comb begin
      a_d      = cur;
      a_d.cand = cur.m | (ValW'(1) << Bit);
      k        = {a_d.cand, 1'b0} - KW'(1);
      a_d.ksq  = KsqW'(k) * KsqW'(k);
    end

    always_comb begin
      b_d  = a_q[j];
      prod = ProdW'(a_q[j].ksq) * ProdW'(a_q[j].c);
      if (prod <= Lim) begin
        b_d.m = a_q[j].cand;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_a_q[j] <= '0;
        ctl_b_q[j] <= '0;
      end else if (en_i) begin
        ctl_a_q[j] <= ctl_in;
        ctl_b_q[j] <= ctl_a_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[j] <= a_d;
        b_q[j] <= b_d;
      end
    end
  end

  assign ctl_o = ctl_b_q[ValW-1];
  assign m_o   = b_q[ValW-1].m;

endmodule

### rtl/core/radial_light_falloff_mask_unit.sv
// Radial light falloff mask, top level: config registers, pipeline, output skid.
// Depends on rlfm_pkg, rlfm_front, rlfm_div, rlfm_cube, rlfm_root.
//
// Takes one pixel coordinate per clock while in_ready_o is high and returns one
// mask byte per transaction, round(255 * t^-1.5) with t = 1 + 2.6*(u^2+v^2)
// around a lamp at (0.42W, 1.06H); coordinates outside the frame give 0 with
// outside_frame set. The pipeline is 41 stages deep (3 front end, 17 divider,
// 5 for t^3, 16 for the byte search) and feeds an output register. in_ready_o
// drops only while the output skid register holds a result that the sink has not
// taken; the whole pipeline then holds. Width and height writes above 4096
// saturate to 4096 and must be made with no transaction in flight.
module radial_light_falloff_mask_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rlfm_pkg::pixel_in_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rlfm_pkg::mask_out_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [rlfm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rlfm_pkg::CfgW-1:0]      cfg_data_i
);
  import rlfm_pkg::*;

  logic [CfgW-1:0]      width_q, height_q, cfg_sat;
  logic                 en;
  ctl_t                 ctl_f, ctl_d, ctl_c, ctl_r;
  logic [1:0][DivW-1:0] dividend;
  logic [1:0][DenW-1:0] den;
  logic [1:0][QuoW-1:0] quo;
  logic [CubeW-1:0]     cube;
  logic [ValW-1:0]      m;
  mask_out_t            res;
  logic                 out_valid_q, skid_valid_q, out_fire;
  mask_out_t            out_q, skid_q;

  assign cfg_sat = (cfg_data_i > CfgW'(MaxDim)) ? CfgW'(MaxDim) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgFrameWidth) begin
        width_q <= cfg_sat;
      end else if (cfg_idx_i == CfgFrameHeight) begin
        height_q <= cfg_sat;
      end
    end
  end

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  rlfm_front u_front (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i, .in_data_i,
    .width_i(width_q), .height_i(height_q),
    .ctl_o(ctl_f), .dividend_o(dividend), .den_o(den)
  );

  rlfm_div u_div (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctl_f), .dividend_i(dividend), .den_i(den),
    .ctl_o(ctl_d), .quo_o(quo)
  );

  rlfm_cube u_cube (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctl_d), .quo_i(quo),
    .ctl_o(ctl_c), .cube_o(cube)
  );

  rlfm_root u_root (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctl_c), .cube_i(cube),
    .ctl_o(ctl_r), .m_o(m)
  );

  assign res.mask_value    = ctl_r.outside ? '0 : m;
  assign res.outside_frame = ctl_r.outside;
  assign out_fire          = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (ctl_r.valid) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (ctl_r.valid) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sim/radial_light_falloff_mask_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for radial_light_falloff_mask_unit: directed and random pixel streams
// checked against a bit-exact falloff predictor, with random idling on both channels.
// Depends on rlfm_pkg and the radial_light_falloff_mask_unit RTL.
module radial_light_falloff_mask_unit_tb;
  import rlfm_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 48;
  localparam int HoldCycles  = 300;
  localparam int MaxReported = 10;
  localparam int CoordMax    = (1 << CoordW) - 1;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  pixel_in_t          in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  mask_out_t          out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;

  int        frame_w;
  int        frame_h;
  mask_out_t expected_masks[$];
  int        mask_errors   = 0;
  int        masks_checked = 0;
  int        pixels_sent   = 0;
  int        tx_gap_max    = 12;
  int        rx_stall_max  = 12;
  int        rx_hold       = 0;
  int        cycles        = 0;

  radial_light_falloff_mask_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d masks outstanding", cycles,
               expected_masks.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // round(num * 2^16 / den), half away from zero
  function automatic longint q16_offset(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag * 65536 + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic mask_out_t lamp_mask(input logic [CoordW-1:0] x,
                                          input logic [CoordW-1:0] y);
    longint          xs, ys, w, h, rad, uq, vq;
    longint unsigned sq, t, cube, k;
    logic [ValW-1:0] m, cand;
    mask_out_t       r;
    xs = longint'(x);
    ys = longint'(y);
    w  = longint'(frame_w);
    h  = longint'(frame_h);
    r  = '0;
    if (xs >= w || ys >= h) begin
      r.outside_frame = 1'b1;
    end else begin
      rad  = (62 * w > 155 * h) ? 62 * w : 155 * h;
      uq   = q16_offset(100 * xs + 50 - 42 * w, rad);
      vq   = q16_offset(100 * ys + 50 - 106 * h, 135 * h);
      sq   = uq * uq + vq * vq;
      t    = 64'd65536 + (26 * sq + 64'd327680) / 64'd655360;
      cube = (t * t * t) >> 32;
      // largest m with (2m-1)^2 * t^3 <= (2*255)^2
      m = '0;
      for (int b = ValW - 1; b >= 0; b--) begin
        cand = m | (8'd1 << b);
        k = 2 * longint'(cand) - 1;
        if (k * k * cube <= (64'd260100 << 16)) m = cand;
      end
      r.mask_value = m;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : check_masks
    mask_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_masks.size() == 0) begin
        mask_errors++;
        if (mask_errors <= MaxReported)
          $display("Unexpected transaction: mask %0d outside %0b",
                   out_data_o.mask_value, out_data_o.outside_frame);
      end else begin
        want = expected_masks.pop_front();
        masks_checked++;
        if (out_data_o.mask_value !== want.mask_value ||
            out_data_o.outside_frame !== want.outside_frame) begin
          mask_errors++;
          if (mask_errors <= MaxReported)
            $display("Mismatch on result %0d: expected mask %0d outside %0b, got %0d %0b",
                     masks_checked, want.mask_value, want.outside_frame,
                     out_data_o.mask_value, out_data_o.outside_frame);
        end
      end
    end
  end

  initial begin : sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) stall = $urandom_range(0, rx_stall_max);
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input int x, input int y);
    int        gap;
    pixel_in_t px;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    px.pixel_x = CoordW'(x);
    px.pixel_y = CoordW'(y);
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    expected_masks.push_back(lamp_mask(CoordW'(x), CoordW'(y)));
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_masks.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_frame_reg(input logic [CfgIdxW-1:0] idx, input int value);
    int sat;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    sat = (value > MaxDim) ? MaxDim : value;
    if (idx == CfgFrameWidth) frame_w = sat;
    else if (idx == CfgFrameHeight) frame_h = sat;
  endtask

  task automatic new_frame(input int w, input int h);
    wait_drained();
    set_frame_reg(CfgFrameWidth, w);
    set_frame_reg(CfgFrameHeight, h);
  endtask

  task automatic test_reset_frame();
    send_pixel(0, 0);
    send_pixel(107, 25);
    send_pixel(45, 25);
    send_pixel(107, 0);
    send_pixel(0, 25);
    send_pixel(108, 0);
    send_pixel(0, 26);
    send_pixel(CoordMax, CoordMax);
  endtask

  task automatic test_frame_registers();
    new_frame(MaxDim, MaxDim);
    send_pixel(0, 0);
    send_pixel(CoordMax, CoordMax);
    send_pixel(1720, CoordMax);
    new_frame(1, 1);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    // wide and short: horizontal radius from width
    new_frame(MaxDim, 1);
    send_pixel(CoordMax, 0);
    send_pixel(1720, 0);
    // narrow and tall: horizontal radius from height
    new_frame(1, MaxDim);
    send_pixel(0, CoordMax);
    send_pixel(0, 0);
    new_frame(0, 26);
    send_pixel(0, 0);
    new_frame(108, 0);
    send_pixel(0, 0);
    new_frame((1 << CfgW) - 1, MaxDim + 1);
    send_pixel(CoordMax, CoordMax);
    // writes to unused indexes must leave the frame alone
    new_frame(100, 20);
    set_frame_reg(CfgSpareA, 0);
    set_frame_reg(CfgSpareB, 0);
    send_pixel(99, 19);
  endtask

  task automatic test_random_frames();
    int w, h, x, y;
    for (int phase = 0; phase < 6; phase++) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxDim) : $urandom_range(1, 160);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxDim) : $urandom_range(1, 160);
      if ($urandom_range(0, 5) == 0) w = $urandom_range(MaxDim + 1, (1 << CfgW) - 1);
      if ($urandom_range(0, 5) == 0) h = $urandom_range(MaxDim + 1, (1 << CfgW) - 1);
      tx_gap_max   = (phase % 4 == 1 || phase % 4 == 3) ? 0 : 12;
      rx_stall_max = (phase % 4 == 2 || phase % 4 == 3) ? 0 : 12;
      new_frame(w, h);
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          x = $urandom_range(0, CoordMax);
          y = $urandom_range(0, CoordMax);
        end else begin
          x = $urandom_range(0, frame_w - 1);
          y = $urandom_range(0, frame_h - 1);
        end
        send_pixel(x, y);
      end
    end
  endtask

  task automatic test_output_backpressure();
    new_frame(200, 64);
    tx_gap_max   = 0;
    rx_stall_max = 0;
    rx_hold      = HoldCycles;
    for (int i = 0; i < 60; i++)
      send_pixel($urandom_range(0, frame_w - 1), $urandom_range(0, frame_h - 1));
    wait_drained();
  endtask

  initial begin
    frame_w = int'(WidthRst);
    frame_h = int'(HeightRst);
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_frame();
    test_frame_registers();
    test_random_frames();
    test_output_backpressure();
    mask_errors += expected_masks.size();
    $display("Sent %0d pixels, checked %0d masks, %0d errors", pixels_sent,
             masks_checked, mask_errors);
    $display("Frames from 0 to 8191 written, unused indexes, a %0d-cycle sink hold",
             HoldCycles);
    if (mask_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
